// ===== rtl/core/jtl_pkg.sv =====
// Package with token codes, scan modes and keyword tables for the JSON token lexer.
`timescale 1ns / 1ps

package jtl_pkg;

  typedef enum logic [3:0] {
    TK_LBRACE   = 4'd0,
    TK_RBRACE   = 4'd1,
    TK_LBRACKET = 4'd2,
    TK_RBRACKET = 4'd3,
    TK_COLON    = 4'd4,
    TK_COMMA    = 4'd5,
    TK_STRBYTE  = 4'd6,
    TK_STREND   = 4'd7,
    TK_TRUE     = 4'd8,
    TK_FALSE    = 4'd9,
    TK_NULL     = 4'd10,
    TK_ERROR    = 4'd11,
    TK_END      = 4'd12
  } token_kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_STRING  = 2'd1,
    MODE_KEYWORD = 2'd2
  } scan_mode_t;

  localparam logic [1:0] KW_TRUE  = 2'd0;
  localparam logic [1:0] KW_FALSE = 2'd1;
  localparam logic [1:0] KW_NULL  = 2'd2;

  localparam int unsigned MAX_RESULTS = 3;

  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_T        = 8'h74;
  localparam logic [7:0] CH_F        = 8'h66;
  localparam logic [7:0] CH_N        = 8'h6E;

  function automatic logic [7:0] kw_char(input logic [1:0] sel, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (sel)
      KW_TRUE: begin
        case (pos)
          3'd0: c = "t";
          3'd1: c = "r";
          3'd2: c = "u";
          3'd3: c = "e";
          default: c = 8'h00;
        endcase
      end
      KW_FALSE: begin
        case (pos)
          3'd0: c = "f";
          3'd1: c = "a";
          3'd2: c = "l";
          3'd3: c = "s";
          3'd4: c = "e";
          default: c = 8'h00;
        endcase
      end
      default: begin
        case (pos)
          3'd0: c = "n";
          3'd1: c = "u";
          3'd2: c = "l";
          3'd3: c = "l";
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] sel);
    return (sel == KW_FALSE) ? 3'd5 : 3'd4;
  endfunction

  function automatic token_kind_t kw_token(input logic [1:0] sel);
    token_kind_t k;
    case (sel)
      KW_TRUE:  k = TK_TRUE;
      KW_FALSE: k = TK_FALSE;
      default:  k = TK_NULL;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/core/json_token_lexer.sv =====
// JSON token lexer: one text byte in, zero to three tokens out, on streaming channels.
`timescale 1ns / 1ps

// Takes one byte of JSON text per transfer (in_tlast marks the final byte) and
// produces one token per output transfer; out_tlast marks the last token caused
// by an input byte. Each accepted byte is decoded into a group of up to three tokens
// held in a three-entry result register, which drains one token per cycle while
// out_tready is high; the first token is valid in the cycle after the input transfer.
// A byte that yields zero tokens, or one token taken with out_tready high, lets the
// next byte enter in the following cycle, so the sustained rate is one byte per cycle
// without output stalls; a byte that yields n tokens (n = 2 or 3, e.g. keyword error
// plus reexamined byte, or the end token) holds the input until its last token drains.
module json_token_lexer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [3:0] token_kind, [11:4] string_byte, [15:12] zero
  output logic        out_tlast   // last_result
);

  jtl_pkg::scan_mode_t  mode_r, mode_nxt, mode_mid;
  logic [1:0]           sel_r, sel_nxt, sel_mid;
  logic [2:0]           prog_r, prog_nxt, prog_mid;

  jtl_pkg::token_kind_t kind_r [jtl_pkg::MAX_RESULTS];
  logic [7:0]           byte_r [jtl_pkg::MAX_RESULTS];
  logic [1:0]           cnt_r;

  jtl_pkg::token_kind_t res_kind [jtl_pkg::MAX_RESULTS];
  logic [7:0]           res_byte [jtl_pkg::MAX_RESULTS];
  logic [1:0]           res_cnt;

  logic                 in_fire, out_fire;
  logic [7:0]           b;
  logic                 idle_emit;
  jtl_pkg::token_kind_t idle_kind;
  jtl_pkg::scan_mode_t  idle_mode;
  logic [1:0]           idle_sel;
  logic [2:0]           kw_len_cur;
  logic [2:0]           prog_inc;
  logic                 kw_match;
  logic                 kw_done;

  assign b         = in_tdata;
  assign in_tready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_tready);
  assign in_fire   = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_fire  = out_tvalid && out_tready;

  assign out_tdata = {4'h0, byte_r[0], kind_r[0]};
  assign out_tlast = (cnt_r == 2'd1);

  // Decode of a byte seen in idle mode
  always_comb begin
    idle_emit = 1'b1;
    idle_kind = jtl_pkg::TK_ERROR;
    idle_mode = jtl_pkg::MODE_IDLE;
    idle_sel  = jtl_pkg::KW_TRUE;
    if (b == jtl_pkg::CH_SPACE || (b >= jtl_pkg::CH_TAB && b <= jtl_pkg::CH_CR)) begin
      idle_emit = 1'b0;
    end else begin
      case (b)
        jtl_pkg::CH_LBRACE:   idle_kind = jtl_pkg::TK_LBRACE;
        jtl_pkg::CH_RBRACE:   idle_kind = jtl_pkg::TK_RBRACE;
        jtl_pkg::CH_LBRACKET: idle_kind = jtl_pkg::TK_LBRACKET;
        jtl_pkg::CH_RBRACKET: idle_kind = jtl_pkg::TK_RBRACKET;
        jtl_pkg::CH_COLON:    idle_kind = jtl_pkg::TK_COLON;
        jtl_pkg::CH_COMMA:    idle_kind = jtl_pkg::TK_COMMA;
        jtl_pkg::CH_QUOTE: begin
          idle_emit = 1'b0;
          idle_mode = jtl_pkg::MODE_STRING;
        end
        jtl_pkg::CH_T: begin
          idle_emit = 1'b0;
          idle_mode = jtl_pkg::MODE_KEYWORD;
          idle_sel  = jtl_pkg::KW_TRUE;
        end
        jtl_pkg::CH_F: begin
          idle_emit = 1'b0;
          idle_mode = jtl_pkg::MODE_KEYWORD;
          idle_sel  = jtl_pkg::KW_FALSE;
        end
        jtl_pkg::CH_N: begin
          idle_emit = 1'b0;
          idle_mode = jtl_pkg::MODE_KEYWORD;
          idle_sel  = jtl_pkg::KW_NULL;
        end
        default: idle_kind = jtl_pkg::TK_ERROR;
      endcase
    end
  end

  assign kw_len_cur = jtl_pkg::kw_len(sel_r);
  assign prog_inc   = prog_r + 3'd1;
  assign kw_match   = (prog_r < kw_len_cur) && (b == jtl_pkg::kw_char(sel_r, prog_r));
  assign kw_done    = (prog_inc >= kw_len_cur);

  // Next state
  always_comb begin
    mode_mid = idle_mode;
    sel_mid  = idle_sel;
    prog_mid = (idle_mode == jtl_pkg::MODE_KEYWORD) ? 3'd1 : 3'd0;
    case (mode_r)
      jtl_pkg::MODE_STRING: begin
        mode_mid = (b == jtl_pkg::CH_QUOTE) ? jtl_pkg::MODE_IDLE : jtl_pkg::MODE_STRING;
        sel_mid  = sel_r;
        prog_mid = prog_r;
      end
      jtl_pkg::MODE_KEYWORD: begin
        if (kw_match) begin
          if (kw_done) begin
            mode_mid = jtl_pkg::MODE_IDLE;
            sel_mid  = jtl_pkg::KW_TRUE;
            prog_mid = 3'd0;
          end else begin
            mode_mid = jtl_pkg::MODE_KEYWORD;
            sel_mid  = sel_r;
            prog_mid = prog_inc;
          end
        end
      end
      default: begin
        mode_mid = idle_mode;
      end
    endcase
    if (in_tlast) begin
      mode_nxt = jtl_pkg::MODE_IDLE;
      sel_nxt  = jtl_pkg::KW_TRUE;
      prog_nxt = 3'd0;
    end else begin
      mode_nxt = mode_mid;
      sel_nxt  = sel_mid;
      prog_nxt = prog_mid;
    end
  end

  // Result group for the current byte
  always_comb begin
    logic [1:0] n;
    n = 2'd0;
    for (int i = 0; i < jtl_pkg::MAX_RESULTS; i++) begin
      res_kind[i] = jtl_pkg::TK_END;
      res_byte[i] = 8'h00;
    end
    case (mode_r)
      jtl_pkg::MODE_STRING: begin
        if (b == jtl_pkg::CH_QUOTE) begin
          res_kind[0] = jtl_pkg::TK_STREND;
        end else begin
          res_kind[0] = jtl_pkg::TK_STRBYTE;
          res_byte[0] = b;
        end
        n = 2'd1;
      end
      jtl_pkg::MODE_KEYWORD: begin
        if (kw_match) begin
          if (kw_done) begin
            res_kind[0] = jtl_pkg::kw_token(sel_r);
            n = 2'd1;
          end
        end else begin
          res_kind[0] = jtl_pkg::TK_ERROR;
          n = 2'd1;
          if (idle_emit) begin
            res_kind[1] = idle_kind;
            n = 2'd2;
          end
        end
      end
      default: begin
        if (idle_emit) begin
          res_kind[0] = idle_kind;
          n = 2'd1;
        end
      end
    endcase
    if (in_tlast) begin
      if (mode_mid == jtl_pkg::MODE_STRING) begin
        res_kind[n] = jtl_pkg::TK_STREND;
        n = n + 2'd1;
      end else if (mode_mid == jtl_pkg::MODE_KEYWORD) begin
        res_kind[n] = jtl_pkg::TK_ERROR;
        n = n + 2'd1;
      end
      res_kind[n] = jtl_pkg::TK_END;
      n = n + 2'd1;
    end
    res_cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jtl_pkg::MODE_IDLE;
      sel_r  <= jtl_pkg::KW_TRUE;
      prog_r <= 3'd0;
      cnt_r  <= 2'd0;
    end else begin
      if (in_fire) begin
        mode_r <= mode_nxt;
        sel_r  <= sel_nxt;
        prog_r <= prog_nxt;
        cnt_r  <= res_cnt;
      end else if (out_fire) begin
        cnt_r  <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < jtl_pkg::MAX_RESULTS; i++) begin
        kind_r[i] <= res_kind[i];
        byte_r[i] <= res_byte[i];
      end
    end else if (out_fire) begin
      for (int i = 0; i < jtl_pkg::MAX_RESULTS - 1; i++) begin
        kind_r[i] <= kind_r[i+1];
        byte_r[i] <= byte_r[i+1];
      end
    end
  end

  a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast |=> mode_r == jtl_pkg::MODE_IDLE && prog_r == 3'd0)
    else $error("scan state not cleared after final byte");

  a_kw_progress: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == jtl_pkg::MODE_KEYWORD |-> prog_r != 3'd0 && prog_r < kw_len_cur)
    else $error("keyword progress out of range");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3:0] != jtl_pkg::TK_STRBYTE |-> out_tdata[11:4] == 8'h00)
    else $error("string byte set on non-string token");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3:0] == jtl_pkg::TK_END |-> out_tlast)
    else $error("end token not marked last");

endmodule
